// File: sv/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the serial frame deframer
// Parser state codes, event codes and the fixed framing byte values.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Framing bytes
    localparam logic [7:0] SYNC_FIRST   = 8'hA5;
    localparam logic [7:0] SYNC_SECOND  = 8'h5A;
    localparam logic [7:0] MARK_BYTE    = 8'h80;
    localparam logic [7:0] TRAILER_BYTE = 8'h04;

    // Frame parser states
    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_SYNC2   = 3'd1,
        ST_MARK    = 3'd2,
        ST_LEN     = 3'd3,
        ST_PAYLOAD = 3'd4,
        ST_TRAIL   = 3'd5
    } parse_state_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_CSUM   = 3'd3,
        EV_TRAIL  = 3'd4
    } event_t;

endpackage : sfd_pkg
`default_nettype wire

// File: sv/serial_frame_deframer_xor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor: sync/length/XOR checksum frame deframer
// Parses A5 5A 80 LEN payload CSUM 04 frames from a stream of received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry one received serial byte per request.
//   m_valid/m_ready carry one result per input byte: m_event_res (none,
//   payload byte, frame accepted, checksum error, trailer error) with
//   m_data_byte, m_byte_index and m_frame_length. Downstream drops the
//   payload of a frame that ends in an error.
//   The result passes through the input register, then the result register.
//   Throughput: one byte per cycle while the receiver takes results; the
//   parser state and running XOR are updated combinationally between the
//   two registers, so nothing else limits the rate below one request per
//   clock.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to hunting for the first sync byte with count, length and XOR
//   cleared.
//   When the receiver stalls, the result register holds, the input register
//   fills, and s_ready drops until m_ready returns; no request is lost.
// ----------------------------------------------------------------------------
module serial_frame_deframer_xor
    import sfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_res,
    output logic [7:0]      m_data_byte,
    output logic [7:0]      m_byte_index,
    output logic [7:0]      m_frame_length
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    parse_state_t state_reg, state_next;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   xor_reg, xor_next;

    // Result register
    logic       out_valid_reg;
    event_t     ev_reg, ev_next;
    logic [7:0] dat_reg, dat_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] flen_reg, flen_next;

    logic in_move;
    logic s_accept;

    // Handshake: input stage moves on when the result slot is free or drains
    assign in_move  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || in_move;
    assign s_accept = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_accept) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Frame parser: next state and result for the byte in the input register
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        ev_next    = EV_NONE;
        dat_next   = 8'd0;
        idx_next   = 8'd0;
        flen_next  = 8'd0;
        unique case (state_reg)
            ST_HUNT: begin
                if (in_byte_reg == SYNC_FIRST) begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (in_byte_reg == SYNC_SECOND) begin
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_HUNT;
                    count_next = 8'd0;
                    len_next   = 8'd0;
                    xor_next   = 8'd0;
                end
            end
            ST_MARK: begin
                if (in_byte_reg == MARK_BYTE) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_HUNT;
                    count_next = 8'd0;
                    len_next   = 8'd0;
                    xor_next   = 8'd0;
                end
            end
            ST_LEN: begin
                len_next   = in_byte_reg;
                count_next = 8'd0;
                xor_next   = 8'd0;
                state_next = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (count_reg < len_reg) begin
                    ev_next    = EV_DATA;
                    dat_next   = in_byte_reg;
                    idx_next   = count_reg;
                    flen_next  = len_reg;
                    xor_next   = xor_reg ^ in_byte_reg;
                    count_next = count_reg + 8'd1;
                end else if (in_byte_reg == xor_reg) begin
                    state_next = ST_TRAIL;
                end else begin
                    ev_next    = EV_CSUM;
                    flen_next  = len_reg;
                    state_next = ST_HUNT;
                    count_next = 8'd0;
                    len_next   = 8'd0;
                    xor_next   = 8'd0;
                end
            end
            ST_TRAIL: begin
                ev_next    = (in_byte_reg == TRAILER_BYTE) ? EV_ACCEPT : EV_TRAIL;
                flen_next  = len_reg;
                state_next = ST_HUNT;
                count_next = 8'd0;
                len_next   = 8'd0;
                xor_next   = 8'd0;
            end
            default: begin
                // unused codes: clean restart
                state_next = ST_HUNT;
                count_next = 8'd0;
                len_next   = 8'd0;
                xor_next   = 8'd0;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            count_reg <= 8'd0;
            len_reg   <= 8'd0;
            xor_reg   <= 8'd0;
        end else if (in_move) begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (in_move) begin
            ev_reg   <= ev_next;
            dat_reg  <= dat_next;
            idx_reg  <= idx_next;
            flen_reg <= flen_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = ev_reg;
    assign m_data_byte    = dat_reg;
    assign m_byte_index   = idx_reg;
    assign m_frame_length = flen_reg;

    // Checks
    a_idx_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && ev_reg == EV_DATA) |-> (idx_reg < flen_reg))
        else $error("payload index not below frame length");

    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && ev_reg == EV_NONE) |-> (flen_reg == 8'd0 && dat_reg == 8'd0))
        else $error("no-event result carries non-zero fields");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAYLOAD) |-> (count_reg <= len_reg))
        else $error("payload count beyond frame length");

    a_trail_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_move && state_reg == ST_TRAIL) |=>
        (state_reg == ST_HUNT && count_reg == 8'd0 && xor_reg == 8'd0))
        else $error("parser did not restart after trailer");

    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HUNT) |-> (len_reg == 8'd0 && count_reg == 8'd0))
        else $error("stale frame state while hunting");

endmodule : serial_frame_deframer_xor
`default_nettype wire

// File: verif/tb_serial_frame_deframer_xor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_xor: self-checking bench for the frame deframer
// Feeds directed and random byte streams (good frames, corrupted frames,
// broken headers and line noise) through the request channel. A software
// copy of the frame parser predicts one result per accepted byte, and every
// result taken from the block is checked field by field against the oldest
// prediction. Both channels idle at random, and one long receiver hold-off
// fills the block so that it has to stall its input.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_xor;
    import sfd_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles with no request moving
    localparam int HOLD_CYCLES = 300;   // receiver hold-off length
    localparam int DRAIN_WAIT  = 8;     // extra wait after the last result is taken

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] length;
    } deframe_result_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [2:0] m_event_res;
    logic [7:0] m_data_byte;
    logic [7:0] m_byte_index;
    logic [7:0] m_frame_length;

    // Parser copy used for prediction
    parse_state_t parser_state = ST_HUNT;
    logic [7:0]   payload_seen = 8'h00;
    logic [7:0]   frame_len    = 8'h00;
    logic [7:0]   payload_xor  = 8'h00;

    deframe_result_t expected_results[$];

    int error_count     = 0;
    int src_idle_pct    = 0;
    int snk_idle_pct    = 0;
    int frame_bytes_out = 0;
    int idle_cycles     = 0;
    int hold_left       = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;

    serial_frame_deframer_xor i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_data_byte    (m_data_byte),
        .m_byte_index   (m_byte_index),
        .m_frame_length (m_frame_length)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    task automatic restart_parser();
        parser_state = ST_HUNT;
        payload_seen = 8'h00;
        frame_len    = 8'h00;
        payload_xor  = 8'h00;
    endtask

    // Advance the parser copy by one byte and queue the result it gives
    task automatic parse_byte(input logic [7:0] b);
        deframe_result_t r;
        r = '0;
        r.ev = EV_NONE;
        case (parser_state)
            ST_HUNT: begin
                if (b == SYNC_FIRST) parser_state = ST_SYNC2;
            end
            ST_SYNC2: begin
                // a mismatch here is not re-checked as a first sync byte
                if (b == SYNC_SECOND) parser_state = ST_MARK;
                else restart_parser();
            end
            ST_MARK: begin
                if (b == MARK_BYTE) parser_state = ST_LEN;
                else restart_parser();
            end
            ST_LEN: begin
                frame_len    = b;
                payload_seen = 8'h00;
                payload_xor  = 8'h00;
                parser_state = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (payload_seen < frame_len) begin
                    r.ev         = EV_DATA;
                    r.data       = b;
                    r.index      = payload_seen;
                    r.length     = frame_len;
                    payload_xor  = payload_xor ^ b;
                    payload_seen = payload_seen + 8'd1;
                end else if (b == payload_xor) begin
                    parser_state = ST_TRAIL;
                end else begin
                    r.ev     = EV_CSUM;
                    r.length = frame_len;
                    restart_parser();
                end
            end
            ST_TRAIL: begin
                if (b == TRAILER_BYTE) r.ev = EV_ACCEPT;
                else r.ev = EV_TRAIL;
                r.length = frame_len;
                restart_parser();
            end
            default: restart_parser();
        endcase
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b);
    endtask

    // Whole frame with random payload; checksum and trailer may be spoilt
    task automatic send_frame(input int len, input bit bad_csum, input bit bad_trail);
        logic [7:0] x;
        logic [7:0] b;
        logic [7:0] trail;
        x = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(MARK_BYTE);
        send_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            x = x ^ b;
            send_byte(b);
        end
        if (bad_csum) begin
            send_byte(x ^ 8'($urandom_range(1, 255)));
        end else begin
            send_byte(x);
            trail = TRAILER_BYTE;
            if (bad_trail) begin
                do trail = 8'($urandom_range(0, 255)); while (trail == TRAILER_BYTE);
            end
            send_byte(trail);
        end
        frame_bytes_out += len + 6;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    // Compare each result against the oldest prediction
    always @(posedge aclk) begin
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_event_res, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_event_res !== want.ev)
                    report_mismatch("event", m_event_res, want.ev);
                if (m_data_byte !== want.data)
                    report_mismatch("data byte", m_data_byte, want.data);
                if (m_byte_index !== want.index)
                    report_mismatch("byte index", m_byte_index, want.index);
                if (m_frame_length !== want.length)
                    report_mismatch("frame length", m_frame_length, want.length);
            end
        end
    end

    // Watchdog: too long with no request moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Two-byte payload at both byte extremes, then the trailer
    task automatic test_good_frames();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(MARK_BYTE);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(TRAILER_BYTE);
    endtask

    // Repeated first sync, then a bad mark byte
    task automatic test_sync_errors();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(MARK_BYTE ^ 8'h01);
    endtask

    // Zero-length frames: bad checksum, then good checksum with bad trailer
    task automatic test_frame_errors();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(MARK_BYTE);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(MARK_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Largest frame, reaching the last payload index
    task automatic test_long_frame();
        send_frame(255, 1'b0, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (3) send_frame(4, 1'b0, 1'b0);
    endtask

    // Mostly well-formed frames with random content, some noise and broken headers
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int budget);
        int start;
        int pick;
        int len;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start = frame_bytes_out;
        while (frame_bytes_out - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 99) < 5) len = $urandom_range(0, 255);
                else len = $urandom_range(0, 12);
                send_frame(len, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // header broken at the second sync or the mark byte
                send_byte(SYNC_FIRST);
                if ($urandom_range(0, 1)) send_byte(SYNC_SECOND);
                else send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 10;
        snk_idle_pct = 88;
        test_good_frames();
        test_sync_errors();
        test_frame_errors();
        test_random_traffic(10, 88, 330);
        test_random_traffic(88, 10, 330);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_long_frame();
        test_backpressure();
        test_random_traffic(0, 0, 330);
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule : tb_serial_frame_deframer_xor
`default_nettype wire

// File: sim.f
sv/sfd_pkg.sv
sv/serial_frame_deframer_xor.sv
verif/tb_serial_frame_deframer_xor.sv
